// ----- sv/accel_tilt_roll_pitch_unit_assert.svh -----
// assertion macros for the tilt unit
`ifndef ACCEL_TILT_ROLL_PITCH_UNIT_ASSERT_SVH
`define ACCEL_TILT_ROLL_PITCH_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define ATRP_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("same cycle check failed");
`define ATRP_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("next cycle check failed");
`else
`define ATRP_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define ATRP_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

// ----- sv/atrp_pkg.sv -----
package atrp_pkg;

    localparam int AXIS_W          = 16;
    localparam int OFS_W           = 12;
    localparam int SUM_W           = 17;
    localparam int MAG_W           = 16;
    localparam int SQ_W            = 2 * MAG_W;
    localparam int DEN_W           = SQ_W + 1;
    localparam int SQ_SHIFT        = 16;
    localparam int RAD_W           = ((DEN_W + SQ_SHIFT + 1) / 2) * 2;
    localparam int SQRT_STAGES     = RAD_W / 2;
    localparam int ROOT_W          = SQRT_STAGES;
    localparam int REM_W           = ROOT_W + 3;
    localparam int NUM_SHIFT       = 8;
    localparam int CORDIC_STAGES   = 16;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int ACC_FRAC        = 20;
    localparam int CW              = 28;
    localparam int ZW              = 29;
    localparam int OUT_W           = 14;
    localparam int FULL_ANGLE      = 90 << ANGLE_FRAC_BITS;
    localparam int ROUND_SH        = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int NCH             = 2;
    localparam int DEPTH           = 3 + SQRT_STAGES + CORDIC_STAGES + 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_OFFSET = 2'd2;

    localparam logic signed [OFS_W-1:0] X_OFFSET_RST = -12'sd41;
    localparam logic signed [OFS_W-1:0] Y_OFFSET_RST = 12'sd0;
    localparam logic signed [OFS_W-1:0] Z_OFFSET_RST = 12'sd41;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
        logic [MAG_W-1:0]  num;
        logic              zden;
    } sqrt_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zden;
        logic                 nzero;
    } cord_t;

    function automatic logic signed [ZW-1:0] atan_deg(input int unsigned i);
        case (i)
            0:       return ZW'(47185920);
            1:       return ZW'(27855475);
            2:       return ZW'(14718068);
            3:       return ZW'(7471121);
            4:       return ZW'(3750058);
            5:       return ZW'(1876857);
            6:       return ZW'(938658);
            7:       return ZW'(469357);
            8:       return ZW'(234682);
            9:       return ZW'(117342);
            10:      return ZW'(58671);
            11:      return ZW'(29335);
            12:      return ZW'(14668);
            13:      return ZW'(7334);
            14:      return ZW'(3667);
            15:      return ZW'(1833);
            16:      return ZW'(917);
            17:      return ZW'(458);
            18:      return ZW'(229);
            19:      return ZW'(115);
            20:      return ZW'(57);
            21:      return ZW'(29);
            22:      return ZW'(14);
            23:      return ZW'(7);
            default: return ZW'(0);
        endcase
    endfunction

    function automatic logic [OUT_W-1:0] angle_out(input cord_t c);
        logic signed [ZW-1:0] res;
        res = (c.z + ZW'(1 << (ROUND_SH - 1))) >>> ROUND_SH;
        if (c.zden)
            return c.nzero ? OUT_W'(FULL_ANGLE) : '0;
        else if (c.z <= 0)
            return '0;
        else if (res > ZW'(FULL_ANGLE))
            return OUT_W'(FULL_ANGLE);
        else
            return res[OUT_W-1:0];
    endfunction

endpackage

// ----- sv/atrp_sample_if.sv -----
interface atrp_sample_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [atrp_pkg::AXIS_W-1:0]      accel_x_raw;
    logic signed [atrp_pkg::AXIS_W-1:0]      accel_y_raw;
    logic signed [atrp_pkg::AXIS_W-1:0]      accel_z_raw;

    modport source (output valid, accel_x_raw, accel_y_raw, accel_z_raw, input ready);
    modport sink   (input valid, accel_x_raw, accel_y_raw, accel_z_raw, output ready);
endinterface

// ----- sv/atrp_angle_if.sv -----
interface atrp_angle_if;
    logic                          valid;
    logic                          ready;
    logic [atrp_pkg::OUT_W-1:0]    roll_magnitude;
    logic [atrp_pkg::OUT_W-1:0]    pitch_magnitude;

    modport source (output valid, roll_magnitude, pitch_magnitude, input ready);
    modport sink   (input valid, roll_magnitude, pitch_magnitude, output ready);
endinterface

// ----- sv/accel_tilt_roll_pitch_unit.sv -----
// pipeline: an accepted beat passes through 45 register stages before the output
// (3 front, 25 square-root, 16 cordic, 1 output)
// throughput: one beat per cycle; the whole pipeline holds while the output stalls
// reset: rst_n is asynchronous, active low; clears all valid bits and loads the
// offsets with -41, 0 and 41
`include "accel_tilt_roll_pitch_unit_assert.svh"

module accel_tilt_roll_pitch_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [atrp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [atrp_pkg::OFS_W-1:0]        cfg_data,
    atrp_sample_if.sink                       sample,
    atrp_angle_if.source                      angle
);
    import atrp_pkg::*;

    localparam int AX = 0;
    localparam int AY = 1;
    localparam int AZ = 2;
    localparam int P_SQRT0 = 2;
    localparam int P_CORD0 = P_SQRT0 + SQRT_STAGES + 1;

    logic signed [OFS_W-1:0] x_off_reg;
    logic signed [OFS_W-1:0] y_off_reg;
    logic signed [OFS_W-1:0] z_off_reg;

    logic [DEPTH-1:0] vld_reg;
    logic             adv;
    logic             out_in_range;

    logic signed [SUM_W-1:0] sum_next [3];
    logic [MAG_W-1:0]        mag_reg  [3];
    logic [SQ_W-1:0]         sq_reg   [3];

    sqrt_t sqrt_reg [NCH][SQRT_STAGES+1];
    cord_t cord_reg [NCH][CORDIC_STAGES];
    logic [OUT_W-1:0] ang_reg [NCH];

    assign adv          = !angle.valid || angle.ready;
    assign sample.ready = adv;
    assign angle.valid  = vld_reg[DEPTH-1];
    assign angle.roll_magnitude  = ang_reg[0];
    assign angle.pitch_magnitude = ang_reg[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_off_reg <= X_OFFSET_RST;
            y_off_reg <= Y_OFFSET_RST;
            z_off_reg <= Z_OFFSET_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_X_OFFSET: x_off_reg <= cfg_data;
                REG_Y_OFFSET: y_off_reg <= cfg_data;
                REG_Z_OFFSET: z_off_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], sample.valid};
    end

    // offset and magnitude
    assign sum_next[AX] = SUM_W'(sample.accel_x_raw) + SUM_W'(x_off_reg);
    assign sum_next[AY] = SUM_W'(sample.accel_y_raw) + SUM_W'(y_off_reg);
    assign sum_next[AZ] = SUM_W'(sample.accel_z_raw) + SUM_W'(z_off_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                mag_reg[a] <= sum_next[a][SUM_W-1] ? MAG_W'(-sum_next[a])
                                                   : MAG_W'(sum_next[a]);
                sq_reg[a]  <= SQ_W'(mag_reg[a]) * SQ_W'(mag_reg[a]);
            end
        end
    end

    // the numerator magnitude needs to line up with the squares
    logic [MAG_W-1:0] num_reg [NCH];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg[0] <= mag_reg[AY];
            num_reg[1] <= mag_reg[AX];
        end
    end

    for (genvar ch = 0; ch < NCH; ch++)
    begin : g_ch
        localparam int DB = (ch == 0) ? AX : AY;
        logic [DEN_W-1:0] den;

        assign den = DEN_W'(sq_reg[DB]) + DEN_W'(sq_reg[AZ]);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sqrt_reg[ch][0].rad  <= RAD_W'(den) << SQ_SHIFT;
                sqrt_reg[ch][0].root <= '0;
                sqrt_reg[ch][0].rem  <= '0;
                sqrt_reg[ch][0].num  <= num_reg[ch];
                sqrt_reg[ch][0].zden <= (den == '0);
            end
        end

        // one root bit per stage
        for (genvar k = 0; k < SQRT_STAGES; k++)
        begin : g_sqrt
            sqrt_t            cur;
            sqrt_t            sqrt_next;
            logic [REM_W-1:0] rem_sh;
            logic [REM_W-1:0] trial;

            assign cur    = sqrt_reg[ch][k];
            assign rem_sh = {cur.rem[REM_W-3:0], cur.rad[RAD_W-1 -: 2]};
            assign trial  = REM_W'({cur.root, 2'b01});

            always_comb
            begin
                sqrt_next     = cur;
                sqrt_next.rad = cur.rad << 2;
                if (rem_sh >= trial)
                begin
                    sqrt_next.rem  = rem_sh - trial;
                    sqrt_next.root = {cur.root[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sqrt_next.rem  = rem_sh;
                    sqrt_next.root = {cur.root[ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                    sqrt_reg[ch][k+1] <= sqrt_next;
            end
        end

        // vectoring cordic
        for (genvar i = 0; i < CORDIC_STAGES; i++)
        begin : g_cord
            cord_t                cur;
            cord_t                cord_next;
            logic signed [CW-1:0] dx;
            logic signed [CW-1:0] dy;

            if (i == 0)
            begin : g_init
                assign cur.x     = CW'(sqrt_reg[ch][SQRT_STAGES].root);
                assign cur.y     = CW'(sqrt_reg[ch][SQRT_STAGES].num) <<< NUM_SHIFT;
                assign cur.z     = '0;
                assign cur.zden  = sqrt_reg[ch][SQRT_STAGES].zden;
                assign cur.nzero = (sqrt_reg[ch][SQRT_STAGES].num != '0);
            end
            else
            begin : g_mid
                assign cur = cord_reg[ch][i-1];
            end

            assign dx = cur.y >>> i;
            assign dy = cur.x >>> i;

            always_comb
            begin
                cord_next = cur;
                if (cur.y > 0)
                begin
                    cord_next.x = cur.x + dx;
                    cord_next.y = cur.y - dy;
                    cord_next.z = cur.z + atan_deg(i);
                end
                else
                begin
                    cord_next.x = cur.x - dx;
                    cord_next.y = cur.y + dy;
                    cord_next.z = cur.z - atan_deg(i);
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                    cord_reg[ch][i] <= cord_next;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                ang_reg[ch] <= angle_out(cord_reg[ch][CORDIC_STAGES-1]);
        end
    end

    assign out_in_range = (angle.roll_magnitude <= OUT_W'(FULL_ANGLE)) &&
                          (angle.pitch_magnitude <= OUT_W'(FULL_ANGLE));

    `ATRP_ASSERT_SAME(a_range, clk, rst_n, angle.valid, out_in_range)
    `ATRP_ASSERT_NEXT(a_enter, clk, rst_n, sample.valid && sample.ready, vld_reg[0])
    `ATRP_ASSERT_NEXT(a_hold, clk, rst_n, !adv, $stable(vld_reg))
    `ATRP_ASSERT_NEXT(a_cord, clk, rst_n, adv && vld_reg[P_CORD0-1], vld_reg[P_CORD0])

endmodule
